@@ design/swoi_pkg.sv @@
// Shared types and constants for the stack with ordered insert.
`default_nettype none
package swoi_pkg;

  // Store size and derived widths
  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  // Operation codes on the in_func field
  localparam logic [1:0] FUNC_PUSH   = 2'd0;
  localparam logic [1:0] FUNC_INSERT = 2'd1;
  localparam logic [1:0] FUNC_POP    = 2'd2;

  // Status codes on the out_status field
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  // Datapath operations
  typedef enum logic [1:0] {
    OP_NONE,
    OP_PUSH,
    OP_INSERT,
    OP_POP
  } op_t;

  // Controller states: result slot free or holding a result
  typedef enum logic {
    CS_IDLE,
    CS_HOLD
  } ctl_state_t;

  // Command from controller to datapath
  typedef struct packed {
    logic       load;
    op_t        op;
    logic [1:0] status;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
  } dp_stat_t;

endpackage
`default_nettype wire

@@ design/swoi_datapath.sv @@
// Row of stack cells, fill count and result payload registers.
`default_nettype none
module swoi_datapath (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire swoi_pkg::cmd_t                   cmd,
  input  wire logic signed [swoi_pkg::DATA_W-1:0] in_value,
  output swoi_pkg::dp_stat_t                    stat,
  output logic signed [swoi_pkg::DATA_W-1:0]    out_popped_value,
  output logic [1:0]                            out_status,
  output logic                                  out_not_empty
);
  import swoi_pkg::*;

  logic signed [DATA_W-1:0] entries_r [DEPTH];
  logic signed [DATA_W-1:0] entries_nxt [DEPTH];
  logic [CNT_W-1:0]         count_r;
  logic [CNT_W-1:0]         count_nxt;
  logic [DEPTH-1:0]         stop;
  logic [DEPTH-1:0]         at_or_after;
  logic signed [DATA_W-1:0] popped_r;
  logic [1:0]               status_r;
  logic                     not_empty_r;

  // Flag each cell that may be the insert point
  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cmp
      assign stop[i] = (cmd.op == OP_PUSH) || (count_r == CNT_W'(i)) ||
                       ((count_r > CNT_W'(i)) && !(entries_r[i] < in_value));
    end
  endgenerate

  // Spread the insert point down the row
  always_comb begin
    at_or_after[0] = stop[0];
    for (int k = 1; k < DEPTH; k++) begin
      at_or_after[k] = at_or_after[k-1] | stop[k];
    end
  end

  // Next value of each cell: hold, take the value, or shift
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      always_comb begin
        entries_nxt[i] = entries_r[i];
        unique case (cmd.op)
          OP_PUSH, OP_INSERT: begin
            if (at_or_after[i]) begin
              if (i > 0 && at_or_after[(i > 0) ? i - 1 : 0]) begin
                entries_nxt[i] = entries_r[(i > 0) ? i - 1 : 0];
              end else begin
                entries_nxt[i] = in_value;
              end
            end
          end
          OP_POP: begin
            if (i < DEPTH - 1) begin
              entries_nxt[i] = entries_r[(i < DEPTH - 1) ? i + 1 : i];
            end
          end
          OP_NONE: begin
            entries_nxt[i] = entries_r[i];
          end
          default: begin
            entries_nxt[i] = entries_r[i];
          end
        endcase
      end
    end
  endgenerate

  // Update the fill count
  always_comb begin
    unique case (cmd.op)
      OP_PUSH, OP_INSERT: count_nxt = count_r + CNT_W'(1);
      OP_POP:             count_nxt = count_r - CNT_W'(1);
      default:            count_nxt = count_r;
    endcase
  end

  // Hold the cells
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int k = 0; k < DEPTH; k++) begin
        entries_r[k] <= entries_nxt[k];
      end
    end
  end

  // Hold the count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.load) begin
      count_r <= count_nxt;
    end
  end

  // Capture the result of each transfer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      popped_r    <= (cmd.op == OP_POP) ? entries_r[0] : '0;
      status_r    <= cmd.status;
      not_empty_r <= (count_nxt != '0);
    end
  end

  assign stat.full        = (count_r == CNT_W'(DEPTH));
  assign stat.empty       = (count_r == '0);
  assign out_popped_value = popped_r;
  assign out_status       = status_r;
  assign out_not_empty    = not_empty_r;

endmodule
`default_nettype wire

@@ design/swoi_ctrl.sv @@
// Controller: handshakes, operation decode and result slot state.
`default_nettype none
module swoi_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic [1:0]         in_func,
  input  wire logic               out_ready,
  input  wire swoi_pkg::dp_stat_t stat,
  output logic                    in_ready,
  output logic                    out_valid,
  output swoi_pkg::cmd_t          cmd
);
  import swoi_pkg::*;

  ctl_state_t state_r;
  ctl_state_t state_nxt;
  logic       accept;

  assign accept = in_valid && in_ready;

  // Next state: fill the slot on a transfer, free it when taken
  always_comb begin
    unique case (state_r)
      CS_IDLE: state_nxt = accept ? CS_HOLD : CS_IDLE;
      CS_HOLD: begin
        if (accept) begin
          state_nxt = CS_HOLD;
        end else if (out_ready) begin
          state_nxt = CS_IDLE;
        end else begin
          state_nxt = CS_HOLD;
        end
      end
      default: state_nxt = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Outputs: handshakes and datapath command
  always_comb begin
    out_valid  = (state_r == CS_HOLD);
    in_ready   = (state_r == CS_IDLE) || out_ready;
    cmd.load   = accept;
    cmd.op     = OP_NONE;
    cmd.status = STAT_OK;
    if (accept) begin
      priority if (in_func == FUNC_PUSH || in_func == FUNC_INSERT) begin
        if (stat.full) begin
          cmd.status = STAT_FULL;
        end else begin
          cmd.op = (in_func == FUNC_PUSH) ? OP_PUSH : OP_INSERT;
        end
      end else if (in_func == FUNC_POP) begin
        if (stat.empty) begin
          cmd.status = STAT_EMPTY;
        end else begin
          cmd.op = OP_POP;
        end
      end else begin
        cmd.op = OP_NONE;
      end
    end
  end

endmodule
`default_nettype wire

@@ design/stack_with_ordered_insert_unit.sv @@
// Top level: bounded stack of signed words with push, ordered insert and pop.
//
// Input channel (in_valid/in_ready) carries in_func and in_value: push on
// top, ordered insert above the first entry from the top that is not less
// than the value (or at the bottom), or pop the top. Each transfer gives one
// result on the output channel (out_valid/out_ready): out_popped_value,
// out_status (ok, pop on empty, dropped because full) and out_not_empty.
// The result is valid in the cycle after the input transfer. Throughput is
// one item per cycle while the receiver takes each result: every cell of the
// row compares against the value at once and shifts in the same cycle, and
// the result register is refilled in the cycle it is taken.
// When the receiver stalls, the result is held and in_ready drops until it
// is taken. Reset empties the stack and clears the result slot; stored
// words are not cleared, only the count.
`default_nettype none
module stack_with_ordered_insert_unit (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [1:0]                         in_func,
  input  wire logic signed [swoi_pkg::DATA_W-1:0] in_value,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [swoi_pkg::DATA_W-1:0]      out_popped_value,
  output logic [1:0]                              out_status,
  output logic                                    out_not_empty
);
  import swoi_pkg::*;

  cmd_t     cmd;
  dp_stat_t stat;

  // Control
  swoi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_func   (in_func),
    .out_ready (out_ready),
    .stat      (stat),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // Cells and result registers
  swoi_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_value         (in_value),
    .stat             (stat),
    .out_popped_value (out_popped_value),
    .out_status       (out_status),
    .out_not_empty    (out_not_empty)
  );

endmodule
`default_nettype wire

@@ design/swoi_checker.sv @@
// Port-level checks for the stack with ordered insert, bound to the top level.
`default_nettype none
module swoi_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_valid,
  input wire logic                               in_ready,
  input wire logic [1:0]                         in_func,
  input wire logic                               out_valid,
  input wire logic                               out_ready,
  input wire logic signed [swoi_pkg::DATA_W-1:0] out_popped_value,
  input wire logic [1:0]                         out_status,
  input wire logic                               out_not_empty
);
  import swoi_pkg::*;

  // A stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // Failed operations return zero
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STAT_OK |-> out_popped_value == '0)
    else $error("nonzero value on failed operation");

  // Pop on empty leaves the stack empty
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_EMPTY |-> !out_not_empty)
    else $error("empty pop reports entries");

  // Push or insert always leaves entries and never reports empty
  a_push: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_func == FUNC_PUSH || in_func == FUNC_INSERT)
    |=> out_valid && out_not_empty && out_status != STAT_EMPTY)
    else $error("bad result after push or insert");

endmodule

bind stack_with_ordered_insert_unit swoi_checker u_swoi_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_func          (in_func),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_popped_value (out_popped_value),
  .out_status       (out_status),
  .out_not_empty    (out_not_empty)
);
`default_nettype wire
